// ----- hw/rtl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the ARP cache responder
// Field widths, operation and result codes, register indexes and the layout of
// one cache entry.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int IP_W     = 32;
	localparam int MAC_W    = 48;
	localparam int OPCODE_W = 16;
	localparam int FUNC_W   = 2;
	localparam int KIND_W   = 2;

	localparam int S_DATA_W = OPCODE_W + IP_W + MAC_W + IP_W;
	localparam int M_FLD_W  = 1 + MAC_W + IP_W;
	localparam int M_DATA_W = ((M_FLD_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = MAC_W;

	// input operations
	localparam logic [FUNC_W-1:0] FUNC_RX_ARP  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESOLVE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REQ    = 2'd2;

	localparam logic [OPCODE_W-1:0] ARP_OP_REQUEST = 16'd1;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 8'd1;

	localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} arpc_entry_t;

	localparam int ENTRY_W = $bits(arpc_entry_t);

endpackage

// ----- hw/rtl/arp_cache_responder_core.sv -----
// ----------------------------------------------------------------------------
// arp_cache_responder_core: ARP cache with request and reply handling
// Learns senders of received ARP packets, answers lookups and emits reply and
// broadcast request results.
// ----------------------------------------------------------------------------
// A received packet (tuser 0) or a lookup (tuser 1) walks the whole cache
// through the single read port of the entry RAM, one entry per cycle. Its
// result is registered after the scan, the final step and the emit step, which
// waits until the output register is free; the next request is accepted in the
// cycle after. A packet that needs no reply frees the input straight after the
// final step. A resolve (tuser 2) goes straight to the emit step and frees the
// input once its result is registered. tuser 3 is dropped as it is accepted.
// One request is handled at a time. A finished result waits in the output
// register while the next request is accepted; a further result holds the
// block until the sink takes the waiting one. Valid marks reset to empty at
// once, no clearing pass is needed. Configuration writes are always accepted.
module arp_cache_responder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
	// input requests
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tdata: arp_opcode[15:0], sender_ip[47:16], sender_mac[95:48], tgt_ip[127:96]
	input  logic [arpc_pkg::S_DATA_W-1:0]   s_tdata,
	// tuser: func[1:0]
	input  logic [arpc_pkg::FUNC_W-1:0]     s_tuser,
	// results
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata: found[0], peer_mac[48:1], peer_ip[80:49], zero pad[87:81]
	output logic [arpc_pkg::M_DATA_W-1:0]   m_tdata,
	// tuser: result_kind[1:0]
	output logic [arpc_pkg::KIND_W-1:0]     m_tuser
);

	import arpc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;

	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] own_mac_q;

	logic [FUNC_W-1:0]   func_q;
	logic [OPCODE_W-1:0] opcode_q;
	logic [IP_W-1:0]     sip_q;
	logic [MAC_W-1:0]    smac_q;
	logic [IP_W-1:0]     tip_q;
	logic [IP_W-1:0]     key_q;

	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [MAC_W-1:0] hit_mac_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic                out_valid_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic                out_found_q;
	logic [MAC_W-1:0]    out_mac_q;
	logic [IP_W-1:0]     out_ip_q;

	logic              in_acc;
	logic              issue;
	logic              cmp_hit;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	arpc_entry_t       ram_wentry;
	arpc_entry_t       rd_entry;
	logic [ENTRY_W-1:0] rd_bits;
	logic              reply_due;
	logic              out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign issue     = (state_q == ST_SCAN) && (cnt_q < CNT_W'(ENTRIES));
	assign rd_entry  = arpc_entry_t'(rd_bits);
	assign cmp_hit   = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rd_entry.ip == key_q);
	assign reply_due = (opcode_q == ARP_OP_REQUEST) && (tip_q == own_ip_q);
	assign out_free  = !out_valid_q || m_tready;

	// learn: overwrite a matching entry, else fill the first free one
	assign ram_we          = (state_q == ST_FIN) && (func_q == FUNC_RX_ARP) && (hit_q || free_q);
	assign ram_waddr       = hit_q ? hit_idx_q : free_idx_q;
	assign ram_wentry.ip   = sip_q;
	assign ram_wentry.mac  = smac_q;

	arpc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wentry),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(rd_bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_OWN_IP) begin
				own_ip_q <= cfg_data[IP_W-1:0];
			end else if (cfg_index == REG_OWN_MAC) begin
				own_mac_q <= cfg_data[MAC_W-1:0];
			end
		end
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q   <= s_tuser;
			opcode_q <= s_tdata[OPCODE_W-1:0];
			sip_q    <= s_tdata[OPCODE_W+IP_W-1:OPCODE_W];
			smac_q   <= s_tdata[OPCODE_W+IP_W+MAC_W-1:OPCODE_W+IP_W];
			tip_q    <= s_tdata[S_DATA_W-1:OPCODE_W+IP_W+MAC_W];
			key_q    <= (s_tuser == FUNC_RX_ARP) ? s_tdata[OPCODE_W+IP_W-1:OPCODE_W]
			                                     : s_tdata[S_DATA_W-1:OPCODE_W+IP_W+MAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			cnt_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q  <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						if (s_tuser == FUNC_RX_ARP || s_tuser == FUNC_LOOKUP) begin
							state_q <= ST_SCAN;
						end else if (s_tuser == FUNC_RESOLVE) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (cmp_hit && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (cmp_vld_s1 && !valid_q[cmp_idx_s1] && !free_q) begin
						free_q <= 1'b1;
					end
					if (!issue && !cmp_vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (func_q == FUNC_RX_ARP) begin
						if (!hit_q && free_q) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						state_q <= reply_due ? ST_EMIT : ST_IDLE;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scan bookkeeping: compare index is the RAM read address registered, in step with the read data
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= cnt_q[IDX_W-1:0];
		if (state_q == ST_SCAN) begin
			if (cmp_hit && !hit_q) begin
				hit_idx_q <= cmp_idx_s1;
				hit_mac_q <= rd_entry.mac;
			end
			if (cmp_vld_s1 && !valid_q[cmp_idx_s1] && !free_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_ip_q <= (func_q == FUNC_RX_ARP) ? sip_q : tip_q;
			priority if (func_q == FUNC_RX_ARP) begin
				out_kind_q  <= KIND_REPLY;
				out_found_q <= 1'b1;
				out_mac_q   <= smac_q;
			end else if (func_q == FUNC_LOOKUP) begin
				out_kind_q  <= KIND_LOOKUP;
				out_found_q <= hit_q;
				out_mac_q   <= hit_q ? hit_mac_q : '0;
			end else begin
				out_kind_q  <= KIND_REQ;
				out_found_q <= 1'b1;
				out_mac_q   <= MAC_BROADCAST;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {(M_DATA_W - M_FLD_W)'(0), out_ip_q, out_mac_q, out_found_q};

endmodule

// ----- hw/rtl/arpc_ram.sv -----
// ----------------------------------------------------------------------------
// arpc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/arpc_checker.sv -----
// ----------------------------------------------------------------------------
// arpc_checker: port-level checks of the ARP cache responder
// Watches the request and result streams and is bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [arpc_pkg::FUNC_W-1:0]   s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [arpc_pkg::M_DATA_W-1:0] m_tdata,
	input logic [arpc_pkg::KIND_W-1:0]   m_tuser
);

	import arpc_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed or dropped");

	// a request that does work keeps the block busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != FUNC_UNUSED |=> !s_tready)
		else $error("accepted a request while busy");

	// frames to send always report found
	a_frame_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_REPLY || m_tuser == KIND_REQ) |-> m_tdata[0])
		else $error("frame result without found");

	// broadcast request goes to all-ones MAC; a lookup miss reports zero MAC
	a_mac_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != KIND_REQ || m_tdata[MAC_W:1] == MAC_BROADCAST) &&
		             (m_tuser != KIND_LOOKUP || m_tdata[0] || m_tdata[MAC_W:1] == '0))
		else $error("bad peer MAC in result");

endmodule

bind arp_cache_responder_core arpc_checker u_arpc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ----- tb/arp_cache_responder_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_responder_core_test: self-checking bench for the ARP cache core
// Sends received ARP packets, lookups and resolves over the request stream.
// A local copy of the cache and of the interface addresses predicts every
// result, and each result is compared field by field in arrival order. Sink
// stalls run throughout; random source bursts run in the random traffic phases.
// ----------------------------------------------------------------------------
module arp_cache_responder_core_test;
	import arpc_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = ENTRIES + 12;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_ITEMS  = 1920;
	localparam int PHASES        = 6;
	localparam int POOL_SIZE     = 40;
	localparam int MAX_REPORTS   = 10;
	localparam int PAD_W         = M_DATA_W - M_FLD_W;

	// register indexes outside the map, written to show they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

	localparam logic [IP_W-1:0] IP_ALL_ONES = {IP_W{1'b1}};

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [OPCODE_W-1:0] opcode;
		logic [IP_W-1:0]     sender_ip;
		logic [MAC_W-1:0]    sender_mac;
		logic [IP_W-1:0]     tgt_ip;
	} arp_request_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              found;
		logic [MAC_W-1:0]  mac;
		logic [IP_W-1:0]   ip;
		logic [PAD_W-1:0]  pad;
	} arp_answer_t;

	typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SPARSE, SINK_CADENCE} sink_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic [FUNC_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [KIND_W-1:0]     m_tuser;

	// local copy of the cache and the interface addresses
	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] own_mac_q;
	logic [IP_W-1:0]  cache_ip [ENTRIES];
	logic [MAC_W-1:0] cache_mac [ENTRIES];
	logic             cache_valid [ENTRIES];

	arp_answer_t     answers_due [$];
	logic [IP_W-1:0] ip_pool [POOL_SIZE];
	int              mismatches = 0;
	int              answers_seen = 0;
	int unsigned     cycles = 0;

	arp_cache_responder_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int cache_slot(logic [IP_W-1:0] ip);
		for (int i = 0; i < ENTRIES; i++)
			if (cache_valid[i] && cache_ip[i] == ip)
				return i;
		return -1;
	endfunction

	// update the local cache and queue the result this request causes
	function automatic void compute_answer(arp_request_t req);
		int slot;
		arp_answer_t ans;
		ans = '0;
		case (req.func)
			FUNC_RX_ARP: begin
				slot = cache_slot(req.sender_ip);
				if (slot < 0) begin
					// lowest free entry; stays -1 on a full table and the update is dropped
					for (int i = ENTRIES - 1; i >= 0; i--)
						if (!cache_valid[i])
							slot = i;
					if (slot >= 0) begin
						cache_ip[slot]    = req.sender_ip;
						cache_valid[slot] = 1'b1;
					end
				end
				if (slot >= 0)
					cache_mac[slot] = req.sender_mac;
				if (req.opcode == ARP_OP_REQUEST && req.tgt_ip == own_ip_q) begin
					ans.kind  = KIND_REPLY;
					ans.found = 1'b1;
					ans.mac   = req.sender_mac;
					ans.ip    = req.sender_ip;
					answers_due.push_back(ans);
				end
			end
			FUNC_LOOKUP: begin
				slot = cache_slot(req.tgt_ip);
				ans.kind = KIND_LOOKUP;
				ans.ip   = req.tgt_ip;
				if (slot >= 0) begin
					ans.found = 1'b1;
					ans.mac   = cache_mac[slot];
				end
				answers_due.push_back(ans);
			end
			FUNC_RESOLVE: begin
				ans.kind  = KIND_REQ;
				ans.found = 1'b1;
				ans.mac   = MAC_BROADCAST;
				ans.ip    = req.tgt_ip;
				answers_due.push_back(ans);
			end
			FUNC_UNUSED: ;
		endcase
	endfunction

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	always @(posedge clk) begin : check_answers
		arp_answer_t got;
		arp_answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[0], m_tdata[MAC_W:1], m_tdata[M_FLD_W-1:MAC_W+1],
				m_tdata[M_DATA_W-1:M_FLD_W]};
			answers_seen++;
			if (answers_due.size() == 0) begin
				flag_error($sformatf("result %0d with none pending: kind %0d found %0b mac %h ip %h",
					answers_seen, got.kind, got.found, got.mac, got.ip));
			end else begin
				want = answers_due.pop_front();
				if (got !== want)
					flag_error($sformatf({"result %0d mismatch: expected kind %0d found %0b ",
						"mac %h ip %h pad %h, got kind %0d found %0b mac %h ip %h pad %h"},
						answers_seen, want.kind, want.found, want.mac, want.ip, want.pad,
						got.kind, got.found, got.mac, got.ip, got.pad));
			end
		end
	end

	// sink stalls: switch to a randomly chosen stall pattern after each run of random length
	initial begin : sink_stalls
		sink_mode_t mode;
		int run;
		m_tready = 1'b0;
		mode = SINK_OPEN;
		run = 0;
		forever begin
			@(negedge clk);
			if (run == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				run = $urandom_range(16, 160);
			end
			run--;
			case (mode)
				SINK_OPEN:    m_tready <= 1'b1;
				SINK_RANDOM:  m_tready <= 1'($urandom_range(0, 1));
				SINK_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
				SINK_CADENCE: m_tready <= ((run % 6) < 3);
			endcase
		end
	end

	task automatic send_request(arp_request_t req);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= req.func;
		s_tdata  <= {req.tgt_ip, req.sender_mac, req.sender_ip, req.opcode};
		do @(posedge clk); while (!s_tready);
		compute_answer(req);
	endtask

	task automatic pause_sending(int n);
		if (n > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// hold the source until every result is in and the block has gone quiet
	task automatic wait_drained();
		pause_sending(1);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_OWN_IP)
			own_ip_q = value[IP_W-1:0];
		else if (idx == REG_OWN_MAC)
			own_mac_q = value[MAC_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
		wait_drained();
		write_reg(REG_OWN_IP, CFG_DATA_W'(ip));
		write_reg(REG_OWN_MAC, mac);
	endtask

	function automatic arp_request_t make_request(logic [FUNC_W-1:0] func,
		logic [OPCODE_W-1:0] opcode, logic [IP_W-1:0] sip, logic [MAC_W-1:0] smac,
		logic [IP_W-1:0] tip);
		arp_request_t req;
		req.func       = func;
		req.opcode     = opcode;
		req.sender_ip  = sip;
		req.sender_mac = smac;
		req.tgt_ip     = tip;
		return req;
	endfunction

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return MAC_BROADCAST;
			default: return r[MAC_W-1:0];
		endcase
	endfunction

	// mostly addresses from a small pool so that lookups hit and entries get updated
	function automatic logic [IP_W-1:0] rand_ip();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (pick == 6)
			return own_ip_q;
		if (pick == 7)
			return $urandom_range(0, 1) ? IP_ALL_ONES : '0;
		return $urandom;
	endfunction

	function automatic arp_request_t rand_request();
		arp_request_t req;
		logic [31:0] r;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			req.func = FUNC_RX_ARP;
		else if (roll < 75)
			req.func = FUNC_LOOKUP;
		else if (roll < 90)
			req.func = FUNC_RESOLVE;
		else
			req.func = FUNC_UNUSED;
		r = $urandom;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			req.opcode = ARP_OP_REQUEST;
		else if (roll < 7)
			req.opcode = {14'd0, r[1:0]};
		else
			req.opcode = r[OPCODE_W-1:0];
		req.sender_ip  = rand_ip();
		req.sender_mac = rand_mac();
		if (req.func == FUNC_RX_ARP && $urandom_range(0, 9) < 4)
			req.tgt_ip = own_ip_q;
		else
			req.tgt_ip = rand_ip();
		return req;
	endfunction

	// reset addresses: own IP is zero, so a request for 0.0.0.0 is answered
	task automatic test_defaults();
		send_request(make_request(FUNC_LOOKUP, '0, '0, '0, '0));
		send_request(make_request(FUNC_RX_ARP, ARP_OP_REQUEST, '0, MAC_BROADCAST, '0));
		send_request(make_request(FUNC_LOOKUP, '0, '0, '0, '0));
		send_request(make_request(FUNC_RESOLVE, '0, '0, '0, '0));
	endtask

	task automatic test_config_regs();
		configure(IP_ALL_ONES, MAC_BROADCAST);
		write_reg(REG_UNMAPPED_LO, rand_mac());
		write_reg(REG_UNMAPPED_HI, rand_mac());
		send_request(make_request(FUNC_RX_ARP, ARP_OP_REQUEST, 32'hC0A8_0001,
			48'h0200_0000_0001, IP_ALL_ONES));
		send_request(make_request(FUNC_RX_ARP, ARP_OP_REQUEST, 32'hC0A8_0001,
			48'h0200_0000_0002, '0));
		send_request(make_request(FUNC_RX_ARP, 16'd2, 32'hC0A8_0001,
			48'h0200_0000_0003, IP_ALL_ONES));
		send_request(make_request(FUNC_RX_ARP, 16'hFFFF, 32'hC0A8_0002,
			48'h0200_0000_0004, IP_ALL_ONES));
		send_request(make_request(FUNC_LOOKUP, '0, '0, '0, 32'hC0A8_0001));
		send_request(make_request(FUNC_LOOKUP, '0, '0, '0, IP_ALL_ONES));
	endtask

	task automatic test_learn_update();
		send_request(make_request(FUNC_RX_ARP, '0, IP_ALL_ONES, '0, '0));
		send_request(make_request(FUNC_LOOKUP, '0, '0, '0, IP_ALL_ONES));
		send_request(make_request(FUNC_RX_ARP, '0, IP_ALL_ONES, 48'h5555_AAAA_5555, '0));
		send_request(make_request(FUNC_LOOKUP, ARP_OP_REQUEST, '0, '0, IP_ALL_ONES));
	endtask

	task automatic test_resolve();
		send_request(make_request(FUNC_RESOLVE, ARP_OP_REQUEST, IP_ALL_ONES, MAC_BROADCAST,
			IP_ALL_ONES));
		send_request(make_request(FUNC_RESOLVE, OPCODE_W'($urandom), $urandom, rand_mac(),
			$urandom));
	endtask

	// the unused code must neither learn the sender nor reply
	task automatic test_unused_func();
		send_request(make_request(FUNC_UNUSED, ARP_OP_REQUEST, 32'h0A0A_0A0A,
			48'h0200_0A0A_0A0A, own_ip_q));
		send_request(make_request(FUNC_LOOKUP, '0, '0, '0, 32'h0A0A_0A0A));
	endtask

	task automatic test_random_traffic();
		arp_request_t req;
		int sent;
		int burst;
		int per_phase;
		for (int i = 0; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom;
		per_phase = RANDOM_ITEMS / PHASES;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       configure('0, '0);
				1:       configure(IP_ALL_ONES, MAC_BROADCAST);
				2:       configure(ip_pool[0], rand_mac());
				default: configure($urandom, rand_mac());
			endcase
			sent = 0;
			burst = 0;
			while (sent < per_phase) begin
				if (burst == 0) begin
					burst = $urandom_range(1, 24);
					// one phase runs back to back with no source gaps
					if (phase != 3)
						pause_sending($urandom_range(0, 8));
				end
				req = rand_request();
				send_request(req);
				burst--;
				sent++;
			end
		end
	endtask

	// more new senders than entries fill the table: the rest are dropped but still answered
	task automatic test_table_full();
		logic [IP_W-1:0] kept_ip;
		for (int i = 0; i <= ENTRIES; i++)
			send_request(make_request(FUNC_RX_ARP, ARP_OP_REQUEST, 32'hAC10_0000 + i,
				rand_mac(), own_ip_q));
		send_request(make_request(FUNC_LOOKUP, '0, '0, '0, 32'hAC10_0000));
		send_request(make_request(FUNC_LOOKUP, '0, '0, '0, 32'hAC10_0000 + ENTRIES));
		kept_ip = cache_ip[ENTRIES - 1];
		send_request(make_request(FUNC_RX_ARP, ARP_OP_REQUEST, kept_ip, rand_mac(),
			own_ip_q));
		send_request(make_request(FUNC_LOOKUP, '0, '0, '0, kept_ip));
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		own_ip_q  = '0;
		own_mac_q = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			cache_ip[i]    = '0;
			cache_mac[i]   = '0;
			cache_valid[i] = 1'b0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_defaults();
		test_config_regs();
		test_learn_update();
		test_resolve();
		test_unused_func();
		test_random_traffic();
		test_table_full();

		wait_drained();
		if (mismatches == 0 && answers_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
